### sv/deficit_round_robin_scheduler_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the deficit round robin scheduler
// Clocked concurrent checks with synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef DEFICIT_ROUND_ROBIN_SCHEDULER_UNIT_MACROS_SVH
`define DEFICIT_ROUND_ROBIN_SCHEDULER_UNIT_MACROS_SVH

// Check prop at every rising edge of clk outside reset.
`define DRR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("drr assertion failed");

// Check that cond implies prop in the next cycle.
`define DRR_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("drr assertion failed");

`endif

### sv/drr_pkg.sv
// ---------------------------------------------------------------------------
// drr_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package drr_pkg;

  localparam int NUM_CLASSES = 4;   // ring index arithmetic wraps at CLS_W bits
  localparam int QUEUE_DEPTH = 64;  // pointers wrap at PTR_W bits
  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = PTR_W + 1;
  localparam int RCNT_W  = CLS_W + 1;
  localparam int ADDR_W  = CLS_W + PTR_W;
  localparam int STORE_DEPTH = NUM_CLASSES * QUEUE_DEPTH;
  localparam int LEN_W   = 16;
  localparam int HND_W   = 16;
  localparam int DEF_W   = 17;
  localparam int CID_W   = 4;
  localparam int REG_W   = 16;
  localparam int IDX_W   = 3;

  localparam logic [REG_W-1:0] QUANTUM_RESET = 16'd1514;
  localparam logic [NUM_CLASSES-1:0] MASK_RESET = '1;

  localparam logic [IDX_W-1:0] REG_QUANTUM0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_QUANTUM1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_QUANTUM2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_QUANTUM3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_MASK     = 3'd4;

  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_ENQUEUED   = 3'd0,
    ST_DROP_CLASS = 3'd1,
    ST_DROP_FULL  = 3'd2,
    ST_GIVEN      = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

  typedef struct packed {
    logic    load;
    logic    enq;
    logic    rd;
    logic    send;
    logic    rotate;
    logic    res_set;
    status_t res_code;
    logic    res_pkt;
    logic    push;
  } drr_cmd_t;

  typedef struct packed {
    logic is_enq;
    logic is_deq;
    logic is_peek;
    logic drop_class;
    logic drop_full;
    logic ring_empty;
    logic front_empty;
    logic fits;
    logic out_free;
  } drr_sts_t;

endpackage

### sv/drr_datapath.sv
// ---------------------------------------------------------------------------
// drr_datapath
// Descriptor store, per-class FIFO pointers, deficits, active ring, output.
// ---------------------------------------------------------------------------
`include "deficit_round_robin_scheduler_unit_macros.svh"

module drr_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [drr_pkg::IDX_W-1:0]  cfg_addr,
  input  logic [drr_pkg::REG_W-1:0]  cfg_wdata,
  input  drr_pkg::mode_t             in_mode_d,
  input  logic [drr_pkg::CID_W-1:0]  in_cls_d,
  input  logic [drr_pkg::LEN_W-1:0]  in_len_d,
  input  logic [drr_pkg::HND_W-1:0]  in_hnd_d,
  input  drr_pkg::drr_cmd_t          cmd,
  output drr_pkg::drr_sts_t          sts,
  input  logic                       out_ready,
  output logic                       out_valid,
  output drr_pkg::status_t           out_status,
  output logic [drr_pkg::CLS_W-1:0]  out_class,
  output logic [drr_pkg::LEN_W-1:0]  out_length,
  output logic [drr_pkg::HND_W-1:0]  out_handle
);

  localparam int NC = drr_pkg::NUM_CLASSES;

  logic [drr_pkg::REG_W-1:0]       quantum [NC];
  logic [NC-1:0]                   present;
  logic [drr_pkg::PTR_W-1:0]       head    [NC];
  logic [drr_pkg::PTR_W-1:0]       tail    [NC];
  logic [drr_pkg::CNT_W-1:0]       count   [NC];
  logic [drr_pkg::DEF_W-1:0]       deficit [NC];
  logic [drr_pkg::CLS_W-1:0]       ring    [NC];
  logic [drr_pkg::CLS_W-1:0]       ring_front;
  logic [drr_pkg::RCNT_W-1:0]      ring_count;

  drr_pkg::mode_t                  in_mode;
  logic [drr_pkg::CID_W-1:0]       in_cls;
  logic [drr_pkg::LEN_W-1:0]       in_len;
  logic [drr_pkg::HND_W-1:0]       in_hnd;

  logic [drr_pkg::LEN_W+drr_pkg::HND_W-1:0] mem [drr_pkg::STORE_DEPTH];
  logic [drr_pkg::LEN_W-1:0]       rd_len;
  logic [drr_pkg::HND_W-1:0]       rd_hnd;

  drr_pkg::status_t                res_status;
  logic [drr_pkg::CLS_W-1:0]       res_class;
  logic [drr_pkg::LEN_W-1:0]       res_len;
  logic [drr_pkg::HND_W-1:0]       res_hnd;

  logic [drr_pkg::CLS_W-1:0]       enq_cls;
  logic [drr_pkg::CLS_W-1:0]       fc;
  logic [drr_pkg::CLS_W-1:0]       ring_back;
  logic [drr_pkg::REG_W-1:0]       q_enq;
  logic [drr_pkg::REG_W-1:0]       q_fc;

  assign enq_cls   = in_cls[drr_pkg::CLS_W-1:0];
  assign fc        = ring[ring_front];
  // ring holds a power-of-two number of slots, so the back index just wraps
  assign ring_back = ring_front + ring_count[drr_pkg::CLS_W-1:0];
  assign q_enq     = (quantum[enq_cls] == '0) ? drr_pkg::REG_W'(1) : quantum[enq_cls];
  assign q_fc      = (quantum[fc] == '0) ? drr_pkg::REG_W'(1) : quantum[fc];

  always_comb begin
    sts.is_enq      = (in_mode == drr_pkg::MODE_ENQ);
    sts.is_deq      = (in_mode == drr_pkg::MODE_DEQ);
    sts.is_peek     = (in_mode == drr_pkg::MODE_PEEK);
    sts.drop_class  = (in_cls >= drr_pkg::CID_W'(NC)) || !present[enq_cls];
    sts.drop_full   = (count[enq_cls] >= drr_pkg::CNT_W'(drr_pkg::QUEUE_DEPTH));
    sts.ring_empty  = (ring_count == '0);
    sts.front_empty = (count[fc] == '0);
    sts.fits        = ({1'b0, rd_len} <= deficit[fc]);
    sts.out_free    = !out_valid || out_ready;
  end

  // descriptor store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.enq) begin
      mem[{enq_cls, tail[enq_cls]}] <= {in_len, in_hnd};
    end
    if (cmd.rd) begin
      {rd_len, rd_hnd} <= mem[{fc, head[fc]}];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_mode <= in_mode_d;
      in_cls  <= in_cls_d;
      in_len  <= in_len_d;
      in_hnd  <= in_hnd_d;
    end
    if (cmd.res_set) begin
      res_status <= cmd.res_code;
      res_class  <= cmd.res_pkt ? fc : '0;
      res_len    <= cmd.res_pkt ? rd_len : '0;
      res_hnd    <= cmd.res_pkt ? rd_hnd : '0;
    end
    if (cmd.push) begin
      out_status <= res_status;
      out_class  <= res_class;
      out_length <= res_len;
      out_handle <= res_hnd;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NC; i++) begin
        quantum[i] <= drr_pkg::QUANTUM_RESET;
        head[i]    <= '0;
        tail[i]    <= '0;
        count[i]   <= '0;
        deficit[i] <= '0;
      end
      present    <= drr_pkg::MASK_RESET;
      ring_front <= '0;
      ring_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          drr_pkg::REG_QUANTUM0: quantum[0] <= cfg_wdata;
          drr_pkg::REG_QUANTUM1: quantum[1] <= cfg_wdata;
          drr_pkg::REG_QUANTUM2: quantum[2] <= cfg_wdata;
          drr_pkg::REG_QUANTUM3: quantum[3] <= cfg_wdata;
          drr_pkg::REG_MASK:     present    <= cfg_wdata[NC-1:0];
          default: ;
        endcase
      end
      if (cmd.enq) begin
        tail[enq_cls]  <= tail[enq_cls] + 1'b1;
        count[enq_cls] <= count[enq_cls] + 1'b1;
        // class goes non-empty: join the back of the ring with fresh credit
        if (count[enq_cls] == '0) begin
          ring[ring_back]  <= enq_cls;
          ring_count       <= ring_count + 1'b1;
          deficit[enq_cls] <= drr_pkg::DEF_W'(q_enq);
        end
      end
      if (cmd.send) begin
        deficit[fc] <= deficit[fc] - drr_pkg::DEF_W'(rd_len);
        head[fc]    <= head[fc] + 1'b1;
        count[fc]   <= count[fc] - 1'b1;
        if (count[fc] == drr_pkg::CNT_W'(1)) begin
          ring_front <= ring_front + 1'b1;
          ring_count <= ring_count - 1'b1;
        end
      end
      if (cmd.rotate) begin
        // pop front, push same class at back; count is unchanged
        deficit[fc]     <= deficit[fc] + drr_pkg::DEF_W'(q_fc);
        ring[ring_back] <= fc;
        ring_front      <= ring_front + 1'b1;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DRR_ASSERT(a_ring_bound, clk, rst, ring_count <= drr_pkg::RCNT_W'(NC))
  `DRR_ASSERT(a_ring_empty_fifos, clk, rst,
    !(ring_count == '0) || (count[0] == '0 && count[1] == '0 && count[2] == '0 && count[3] == '0))
  `DRR_ASSERT_NEXT(a_rotate_keeps_count, clk, rst, cmd.rotate, $stable(ring_count))
  `DRR_ASSERT(a_send_nonempty, clk, rst, !cmd.send || (!sts.ring_empty && !sts.front_empty))

endmodule

### sv/drr_ctrl.sv
// ---------------------------------------------------------------------------
// drr_ctrl
// Sequencer: decode an item, read the head descriptor, rotate, deliver.
// ---------------------------------------------------------------------------
module drr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  drr_pkg::drr_sts_t sts,
  output drr_pkg::drr_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DONE
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    cmd.res_code = drr_pkg::ST_EMPTY;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        cmd.res_set = 1'b1;
        if (sts.is_enq) begin
          if (sts.drop_class) begin
            cmd.res_code = drr_pkg::ST_DROP_CLASS;
          end else if (sts.drop_full) begin
            cmd.res_code = drr_pkg::ST_DROP_FULL;
          end else begin
            cmd.enq      = 1'b1;
            cmd.res_code = drr_pkg::ST_ENQUEUED;
          end
        end else if ((!sts.is_deq && !sts.is_peek) || sts.ring_empty || sts.front_empty) begin
          cmd.res_code = drr_pkg::ST_EMPTY;
        end else begin
          cmd.res_set = 1'b0;
          cmd.rd      = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        if (sts.is_peek || sts.fits) begin
          cmd.send     = !sts.is_peek;
          cmd.res_set  = 1'b1;
          cmd.res_code = drr_pkg::ST_GIVEN;
          cmd.res_pkt  = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.rotate = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b0;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == S_IDLE);
    end
  end

endmodule

### sv/deficit_round_robin_scheduler_unit.sv
// ---------------------------------------------------------------------------
// deficit_round_robin_scheduler_unit
// Deficit weighted round robin over four class FIFOs of packet descriptors.
// ---------------------------------------------------------------------------
//
//   channel   dir  word contents
//   s_*       in   tuser: mode; tdata: class_id, packet_length, packet_handle
//   m_*       out  tuser: status; tdata: out_class, out_length, out_handle
//   cfg_*     in   write of quantum_class0..3 (index 0..3), class mask (4)
//
// Sequence: enqueue, drop, empty and no-op words are decoded and then wait
// for the output register; peek and dequeue add a registered head read, and
// dequeue adds one store read and one compare for every class rotated to the
// back of the ring. Every head look-up is one registered read of the
// single-port descriptor store. One word is in work at a time.
// Reset: synchronous; clears pointers, counts, deficits and the ring, and
// loads quantum 1514 and mask all ones. Store contents are not cleared.
// Stalls: a finished result sits in the output register while the next
// word is taken; s_tready drops only in reset, while a word is in work or
// while its result waits for the output register.
// ---------------------------------------------------------------------------
module deficit_round_robin_scheduler_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [39:0]               s_tdata,   // class_id[3:0], packet_length[19:4],
                                               // packet_handle[35:20], zero fill
  input  logic [1:0]                s_tuser,   // mode[1:0]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [39:0]               m_tdata,   // out_class[1:0], out_length[17:2],
                                               // out_handle[33:18], zero fill
  output logic [2:0]                m_tuser,   // status[2:0]
  input  logic                      cfg_we,
  input  logic [drr_pkg::IDX_W-1:0] cfg_addr,
  input  logic [drr_pkg::REG_W-1:0] cfg_wdata
);

  drr_pkg::drr_cmd_t               cmd;
  drr_pkg::drr_sts_t               sts;
  drr_pkg::status_t                out_status;
  logic [drr_pkg::CLS_W-1:0]       out_class;
  logic [drr_pkg::LEN_W-1:0]       out_length;
  logic [drr_pkg::HND_W-1:0]       out_handle;

  drr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // unpack the input word straight into the datapath capture registers
  drr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_mode_d  (drr_pkg::mode_t'(s_tuser)),
    .in_cls_d   (s_tdata[3:0]),
    .in_len_d   (s_tdata[19:4]),
    .in_hnd_d   (s_tdata[35:20]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (out_status),
    .out_class  (out_class),
    .out_length (out_length),
    .out_handle (out_handle)
  );

  // pack the result word, zero fill to whole bytes
  assign m_tdata = {6'd0, out_handle, out_length, out_class};
  assign m_tuser = out_status;

endmodule
